/* sv/xhd_pkg.sv */
package xhd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAP_COUNT       = 11;
    localparam int HEADER_BYTES    = 256;
    localparam int MAX_OUT         = 65536;
    localparam int TABLE_BITS      = 15;
    localparam int HIST_BITS       = 16;

    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_NEED     = 3'd3,
        ST_BAD      = 3'd4,
        ST_DONE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DECODE = 2'd1,
        PH_BAD    = 2'd2
    } t_phase;

    typedef struct packed {
        logic       en;
        logic [3:0] cnt;
    } t_pop;

    typedef struct packed {
        logic [31:0] bits;
        logic [5:0]  nb;
        logic [3:0]  k;
        logic        stall;
    } t_fetch;

    // Refills one little-endian word when fewer than need bits are buffered.
    function automatic t_fetch fetch_word(logic [4:0] need, logic [31:0] bits,
                                          logic [5:0] nb, logic [3:0] k,
                                          logic [6:0] cnt, logic ended,
                                          logic [15:0] w);
        t_fetch r;
        r.bits  = bits;
        r.nb    = nb;
        r.k     = k;
        r.stall = 1'b0;
        if (nb < {1'b0, need}) begin
            if ({3'b0, k} + 7'd2 > cnt) begin
                r.stall = !ended;
            end else begin
                r.bits = bits | ({16'b0, w} << (6'd16 - nb));
                r.nb   = nb + 6'd16;
                r.k    = k + 4'd2;
            end
        end
        return r;
    endfunction

endpackage

/* sv/xhd_queue.sv */
module xhd_queue #(
    parameter int QUEUE_DEPTH = xhd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic                               i_push,
    input  logic [7:0]                         i_data,
    input  xhd_pkg::t_pop                      i_pop,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output logic [7:0]                         o_taps [xhd_pkg::TAP_COUNT]
);
    import xhd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [7:0]    r_q [QUEUE_DEPTH];
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
        end else if (i_push) begin
            r_count <= r_count + CW'(1);
        end else if (i_pop.en) begin
            r_count <= r_count - CW'(i_pop.cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_count[IW-1:0]] <= i_data;
        end else if (i_pop.en) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                for (int j = 1; j <= TAP_COUNT; j++) begin
                    if (i + j < QUEUE_DEPTH && i_pop.cnt == 4'(j)) begin
                        r_q[i] <= r_q[i + j];
                    end
                end
            end
        end
    end

    assign o_count = r_count;

    always_comb begin
        for (int t = 0; t < TAP_COUNT; t++) begin
            o_taps[t] = r_q[t];
        end
    end

endmodule

/* sv/xpress_huffman_decoder_core.sv */
// Streaming LZ77+Huffman chunk decoder.
// Input channel (i_in_valid/o_in_ready) carries one beat per item: i_kind 0 pushes
// i_in_byte with its end mark, i_kind 1 pulls one decompressed byte. Output channel
// (o_out_valid/i_out_ready) returns exactly one beat per item: a byte, or a status.
// The configuration port writes the expected output length and starts a new chunk.
// The block works on one item at a time. A literal is looked up in S_TBL, the first
// byte of a match passes S_TBL, S_MATCH and S_HIST, each further match byte S_HIST;
// the decode table and the history memory each give one registered read per step.
// After the 256th header byte the table is built by walking the 512 code lengths
// once per length (each symbol is read in S_BRD and checked in S_BCK) and writing
// all 32768 table entries once; no item is accepted while the table is built.
// A finished result waits in the output register; the next item is accepted while
// it waits, and that item stalls at its end until the register is free.
// Reset sets the output length to 65536 and clears the chunk state registers and queue.
module xpress_huffman_decoder_core #(
    parameter int QUEUE_DEPTH = xhd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_out_last,
    input  logic        i_cfg_wr_en,
    input  logic [16:0] i_cfg_wr_data
);
    import xhd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TBL   = 9'b000000010,
        S_MATCH = 9'b000000100,
        S_HIST  = 9'b000001000,
        S_OUT   = 9'b000010000,
        S_BRD   = 9'b000100000,
        S_BCK   = 9'b001000000,
        S_BWR   = 9'b010000000,
        S_FILL  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [16:0] r_outlen;
    logic [8:0]  r_hdr_cnt, n_hdr_cnt;
    logic [23:0] r_kraft, n_kraft;
    logic        r_end_seen, n_end_seen;
    logic [31:0] r_bits, n_bits;
    logic [5:0]  r_nb, n_nb;
    logic [16:0] r_pos, n_pos;
    logic [16:0] r_mrem, n_mrem;
    logic [15:0] r_mdist, n_mdist;
    logic [31:0] r_b1, n_b1;
    logic [5:0]  r_nb1, n_nb1;
    logic [3:0]  r_k1, n_k1;
    logic [15:0] r_moff, n_moff;
    logic [32:0] r_mlen, n_mlen;
    logic        r_go_build, n_go_build;
    logic [3:0]  r_bl, n_bl;
    logic [8:0]  r_bs, n_bs;
    logic [14:0] r_span, n_span;
    logic [15:0] r_fill, n_fill;
    logic [7:0]  r_res_byte, n_res_byte;
    t_status     r_res_st, n_res_st;
    logic        r_res_last, n_res_last;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    t_status     r_ostat;
    logic        r_olast;

    logic [12:0] r_tbl_mem [2**TABLE_BITS];
    logic [7:0]  r_hist_mem [2**HIST_BITS];
    logic [7:0]  r_cl_mem [HEADER_BYTES];
    logic [12:0] r_tbl_q;
    logic [7:0]  r_hist_q;
    logic [7:0]  r_cl_q;

    logic                  tbl_we;
    logic [TABLE_BITS-1:0] tbl_waddr;
    logic [12:0]           tbl_wdata;
    logic                  hist_we;
    logic [7:0]            hist_wdata;
    logic [HIST_BITS-1:0]  hist_raddr;
    logic                  cl_we;

    logic          accept;
    logic          out_load;
    logic          q_push;
    t_pop          q_pop;
    logic [CW-1:0] q_count;
    logic [7:0]    taps [TAP_COUNT];
    logic [6:0]    q_cnt7;

    t_fetch      e1, e2;
    logic [3:0]  len, ol, lh, nib;
    logic [8:0]  sym;
    logic [31:0] b2;
    logic [5:0]  nb2;
    logic [15:0] w2;
    logic [7:0]  ext [7];
    logic [16:0] room;
    logic [23:0] kraft_sum;
    logic [8:0]  hdr_next;

    function automatic logic [23:0] kraft_weight(logic [3:0] l);
        return (l == 4'd0) ? 24'd0 : (24'd1 << (4'd15 - l));
    endfunction

    xhd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_wr_en),
        .i_push  (q_push),
        .i_data  (i_in_byte),
        .i_pop   (q_pop),
        .o_count (q_count),
        .o_taps  (taps)
    );

    assign q_cnt7     = 7'(q_count);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    assign e1 = fetch_word(5'd15, r_bits, r_nb, 4'd0, q_cnt7, r_end_seen,
                           {taps[1], taps[0]});

    assign len = r_tbl_q[12:9];
    assign sym = r_tbl_q[8:0];
    assign ol  = sym[7:4];
    assign lh  = sym[3:0];
    assign b2  = r_b1 << len;
    assign nb2 = (r_nb1 > {2'b0, len}) ? r_nb1 - {2'b0, len} : 6'd0;
    assign w2  = (r_k1 == 4'd2) ? {taps[3], taps[2]} : {taps[1], taps[0]};
    assign e2  = fetch_word(5'd16, b2, nb2, r_k1, q_cnt7, r_end_seen, w2);

    always_comb begin
        for (int o = 0; o < 7; o++) begin
            if (e2.k == 4'd4) begin
                ext[o] = taps[o + 4];
            end else if (e2.k == 4'd2) begin
                ext[o] = taps[o + 2];
            end else begin
                ext[o] = taps[o];
            end
        end
    end

    assign room      = r_outlen - r_pos;
    assign nib       = r_bs[0] ? r_cl_q[7:4] : r_cl_q[3:0];
    assign hdr_next  = r_hdr_cnt + 9'd1;
    assign kraft_sum = r_kraft + kraft_weight(i_in_byte[3:0]) +
                       kraft_weight(i_in_byte[7:4]);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_kraft    = r_kraft;
        n_end_seen = r_end_seen;
        n_bits     = r_bits;
        n_nb       = r_nb;
        n_pos      = r_pos;
        n_mrem     = r_mrem;
        n_mdist    = r_mdist;
        n_b1       = r_b1;
        n_nb1      = r_nb1;
        n_k1       = r_k1;
        n_moff     = r_moff;
        n_mlen     = r_mlen;
        n_go_build = r_go_build;
        n_bl       = r_bl;
        n_bs       = r_bs;
        n_span     = r_span;
        n_fill     = r_fill;
        n_res_byte = r_res_byte;
        n_res_st   = r_res_st;
        n_res_last = r_res_last;
        tbl_we     = 1'b0;
        tbl_waddr  = r_fill[TABLE_BITS-1:0];
        tbl_wdata  = 13'd0;
        hist_we    = 1'b0;
        hist_wdata = 8'd0;
        hist_raddr = r_pos[15:0] - r_mdist;
        cl_we      = 1'b0;
        q_push     = 1'b0;
        q_pop      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_byte = 8'd0;
                    n_res_last = 1'b0;
                    n_state    = S_OUT;
                    if (r_phase == PH_BAD) begin
                        n_res_st = ST_BAD;
                    end else if (!i_kind) begin
                        if (r_phase == PH_HEADER) begin
                            cl_we     = 1'b1;
                            n_hdr_cnt = hdr_next;
                            n_kraft   = kraft_sum;
                            n_res_st  = ST_ACCEPTED;
                            if (hdr_next == 9'(HEADER_BYTES)) begin
                                if (kraft_sum > 24'(1 << TABLE_BITS)) begin
                                    n_phase  = PH_BAD;
                                    n_res_st = ST_BAD;
                                end else begin
                                    n_phase    = PH_DECODE;
                                    n_end_seen = i_in_last;
                                    n_go_build = 1'b1;
                                end
                            end else if (i_in_last) begin
                                n_phase  = PH_BAD;
                                n_res_st = ST_BAD;
                            end
                        end else if (r_end_seen || q_cnt7 >= 7'(QUEUE_DEPTH)) begin
                            n_res_st = ST_FULL;
                        end else begin
                            q_push   = 1'b1;
                            n_res_st = ST_ACCEPTED;
                            if (i_in_last) begin
                                n_end_seen = 1'b1;
                            end
                        end
                    end else if (r_phase == PH_HEADER) begin
                        n_res_st = ST_NEED;
                    end else if (r_pos >= r_outlen) begin
                        n_res_st = ST_DONE;
                    end else if (r_mrem != 17'd0) begin
                        n_mrem  = r_mrem - 17'd1;
                        n_state = S_HIST;
                    end else if (e1.stall) begin
                        n_res_st = ST_NEED;
                    end else begin
                        n_b1    = e1.bits;
                        n_nb1   = e1.nb;
                        n_k1    = e1.k;
                        n_state = S_TBL;
                    end
                end
            end
            S_TBL: begin
                n_state    = S_OUT;
                n_res_byte = 8'd0;
                n_res_last = 1'b0;
                if (len == 4'd0) begin
                    n_res_st = ST_BAD;
                    n_phase  = PH_BAD;
                end else if (!sym[8]) begin
                    n_bits     = b2;
                    n_nb       = nb2;
                    q_pop.en   = 1'b1;
                    q_pop.cnt  = r_k1;
                    hist_we    = 1'b1;
                    hist_wdata = sym[7:0];
                    n_pos      = r_pos + 17'd1;
                    n_res_byte = sym[7:0];
                    n_res_st   = ST_BYTE;
                    n_res_last = (r_pos + 17'd1 == r_outlen);
                end else if (e2.stall) begin
                    n_res_st = ST_NEED;
                end else begin
                    if (ol == 4'd0) begin
                        n_moff = 16'd1;
                        n_b1   = e2.bits;
                        n_nb1  = e2.nb;
                    end else begin
                        n_moff = 16'(32'd1 << ol) |
                                 16'(e2.bits >> (6'd32 - {2'b0, ol}));
                        n_b1   = e2.bits << ol;
                        n_nb1  = (e2.nb > {2'b0, ol}) ? e2.nb - {2'b0, ol} : 6'd0;
                    end
                    n_mlen  = 33'(lh) + 33'd3;
                    n_k1    = e2.k;
                    n_state = S_MATCH;
                    if (lh == 4'd15) begin
                        n_res_st = r_end_seen ? ST_BAD : ST_NEED;
                        if ({3'b0, e2.k} + 7'd1 > q_cnt7) begin
                            n_state = S_OUT;
                        end else if (ext[0] != 8'd255) begin
                            n_mlen = 33'd18 + 33'(ext[0]);
                            n_k1   = e2.k + 4'd1;
                        end else if ({3'b0, e2.k} + 7'd3 > q_cnt7) begin
                            n_state = S_OUT;
                        end else if ({ext[2], ext[1]} != 16'd0) begin
                            n_mlen = 33'({ext[2], ext[1]}) + 33'd3;
                            n_k1   = e2.k + 4'd3;
                        end else if ({3'b0, e2.k} + 7'd7 > q_cnt7) begin
                            n_state = S_OUT;
                        end else begin
                            n_mlen = 33'({ext[6], ext[5], ext[4], ext[3]}) + 33'd3;
                            n_k1   = e2.k + 4'd7;
                        end
                        if (n_state == S_OUT && r_end_seen) begin
                            n_phase = PH_BAD;
                        end
                    end
                end
            end
            S_MATCH: begin
                hist_raddr = r_pos[15:0] - r_moff;
                if (17'(r_moff) > r_pos) begin
                    n_res_byte = 8'd0;
                    n_res_last = 1'b0;
                    n_res_st   = ST_BAD;
                    n_phase    = PH_BAD;
                    n_state    = S_OUT;
                end else begin
                    n_bits    = r_b1;
                    n_nb      = r_nb1;
                    q_pop.en  = 1'b1;
                    q_pop.cnt = r_k1;
                    n_mdist   = r_moff;
                    n_mrem    = (r_mlen < 33'(room)) ? 17'(r_mlen - 33'd1) : room - 17'd1;
                    n_state   = S_HIST;
                end
            end
            S_HIST: begin
                hist_we    = 1'b1;
                hist_wdata = r_hist_q;
                n_pos      = r_pos + 17'd1;
                n_res_byte = r_hist_q;
                n_res_st   = ST_BYTE;
                n_res_last = (r_pos + 17'd1 == r_outlen);
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    if (r_go_build) begin
                        n_go_build = 1'b0;
                        n_bl       = 4'd1;
                        n_bs       = 9'd0;
                        n_fill     = 16'd0;
                        n_state    = S_BRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BRD: begin
                n_state = S_BCK;
            end
            S_BCK, S_BWR: begin
                if (r_state == S_BCK && nib == r_bl) begin
                    n_span  = 15'd1 << (4'd15 - r_bl);
                    n_state = S_BWR;
                end else begin
                    if (r_state == S_BWR) begin
                        tbl_we    = 1'b1;
                        tbl_wdata = {r_bl, r_bs};
                        n_fill    = r_fill + 16'd1;
                        n_span    = r_span - 15'd1;
                    end
                    if (r_state == S_BCK || r_span == 15'd1) begin
                        if (r_bs == 9'd511) begin
                            n_bs    = 9'd0;
                            n_bl    = r_bl + 4'd1;
                            n_state = (r_bl == 4'd15) ? S_FILL : S_BRD;
                        end else begin
                            n_bs    = r_bs + 9'd1;
                            n_state = S_BRD;
                        end
                    end
                end
            end
            S_FILL: begin
                if (r_fill[TABLE_BITS]) begin
                    n_state = S_IDLE;
                end else begin
                    tbl_we = 1'b1;
                    n_fill = r_fill + 16'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            if (!i_rst_n) begin
                r_outlen <= 17'(MAX_OUT);
            end else begin
                r_outlen <= (i_cfg_wr_data > 17'(MAX_OUT)) ? 17'(MAX_OUT) : i_cfg_wr_data;
            end
            r_state    <= S_IDLE;
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= '0;
            r_kraft    <= '0;
            r_end_seen <= 1'b0;
            r_bits     <= '0;
            r_nb       <= '0;
            r_pos      <= '0;
            r_mrem     <= '0;
            r_mdist    <= '0;
            r_go_build <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_kraft    <= n_kraft;
            r_end_seen <= n_end_seen;
            r_bits     <= n_bits;
            r_nb       <= n_nb;
            r_pos      <= n_pos;
            r_mrem     <= n_mrem;
            r_mdist    <= n_mdist;
            r_go_build <= n_go_build;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1       <= n_b1;
        r_nb1      <= n_nb1;
        r_k1       <= n_k1;
        r_moff     <= n_moff;
        r_mlen     <= n_mlen;
        r_bl       <= n_bl;
        r_bs       <= n_bs;
        r_span     <= n_span;
        r_fill     <= n_fill;
        r_res_byte <= n_res_byte;
        r_res_st   <= n_res_st;
        r_res_last <= n_res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obyte <= r_res_byte;
            r_ostat <= r_res_st;
            r_olast <= r_res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_q <= r_tbl_mem[e1.bits[31:32-TABLE_BITS]];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_pos[HIST_BITS-1:0]] <= hist_wdata;
        end
        r_hist_q <= r_hist_mem[hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) begin
            r_cl_mem[r_hdr_cnt[7:0]] <= i_in_byte;
        end
        r_cl_q <= r_cl_mem[r_bs[8:1]];
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_status    = r_ostat;
    assign o_out_last  = r_olast;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("Decoder state register is not one-hot.");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_outlen)
        else $error("Output position passed the output length.");

    a_match_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mrem != 17'd0) |-> (r_phase == PH_DECODE))
        else $error("A match is pending outside the decode phase.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWR) |-> !r_fill[TABLE_BITS])
        else $error("Table build wrote past the end of the table.");

endmodule
